// ===== src/tbm_pkg.sv =====
// tbm_pkg: shared types, widths and codes for the token bucket meter
// no dependencies; every other file uses it by scoped names

package tbm_pkg;

  // timestamp and rate format
  localparam int TIME_WIDTH     = 48;
  localparam int RATE_FRAC_BITS = 16;

  // field widths fixed by the interface
  localparam int BITS_W  = 32;  // burst, rate, bucket level
  localparam int LEN_W   = 17;
  localparam int COLOR_W = 2;

  // elapsed time is split in two halves, each no wider than 32 bits
  localparam int HALF_W  = (TIME_WIDTH + 1) / 2;
  localparam int HI_W    = TIME_WIDTH - HALF_W;
  localparam int PP_LO_W = HALF_W + BITS_W;
  localparam int PP_HI_W = HI_W + BITS_W;
  localparam int PROD_W  = TIME_WIDTH + BITS_W;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BURST = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RATE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_AWARE = 2'd2;

  localparam logic [BITS_W-1:0] BURST_RESET = 32'd96000;
  localparam logic [BITS_W-1:0] RATE_RESET  = 32'd65536;

  // color codes
  localparam logic [COLOR_W-1:0] IN_GREEN = 2'd0;
  localparam logic VERDICT_GREEN = 1'b0;
  localparam logic VERDICT_RED   = 1'b1;

  typedef struct packed {
    logic [BITS_W-1:0] burst;
    logic [BITS_W-1:0] rate;
    logic              aware;
  } tbm_cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [COLOR_W-1:0] color;
  } tbm_pkt_t;

endpackage

// ===== src/tbm_delta.sv =====
// tbm_delta: input register stage, elapsed ticks between consecutive arrivals
// depends on tbm_pkg

module tbm_delta (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic [tbm_pkg::TIME_WIDTH-1:0] up_time,
  input  tbm_pkg::tbm_pkt_t              up_pkt,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output logic [tbm_pkg::TIME_WIDTH-1:0] dn_elapsed,
  output tbm_pkg::tbm_pkt_t              dn_pkt
);

  logic                           valid_r;
  logic [tbm_pkg::TIME_WIDTH-1:0] last_r;
  logic [tbm_pkg::TIME_WIDTH-1:0] elapsed_r;
  logic [tbm_pkg::TIME_WIDTH-1:0] elapsed_nxt;
  tbm_pkg::tbm_pkt_t              pkt_r;
  logic                           adv;
  logic                           take;

  assign adv      = !valid_r || dn_ready;
  assign take     = up_valid && adv;
  assign up_ready = adv;

  // wraps modulo the timestamp width
  assign elapsed_nxt = up_time - last_r;

  // control: valid bit and last arrival time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_r  <= '0;
    end else begin
      if (adv) begin
        valid_r <= up_valid;
      end
      if (take) begin
        last_r <= up_time;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      elapsed_r <= elapsed_nxt;
      pkt_r     <= up_pkt;
    end
  end

  assign dn_valid   = valid_r;
  assign dn_elapsed = elapsed_r;
  assign dn_pkt     = pkt_r;

endmodule

// ===== src/tbm_mult.sv =====
// tbm_mult: two-stage token computation, elapsed ticks times rate
// depends on tbm_pkg; partial products then combine, shift and saturate

module tbm_mult (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tbm_pkg::tbm_cfg_t              cfg,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic [tbm_pkg::TIME_WIDTH-1:0] up_elapsed,
  input  tbm_pkg::tbm_pkt_t              up_pkt,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output logic [tbm_pkg::BITS_W-1:0]     dn_earned,
  output tbm_pkg::tbm_pkt_t              dn_pkt
);

  logic                            a_valid_r;
  logic                            b_valid_r;
  logic                            a_adv;
  logic                            b_adv;
  logic [tbm_pkg::HALF_W-1:0]      e_lo;
  logic [tbm_pkg::HI_W-1:0]        e_hi;
  logic [tbm_pkg::PP_LO_W-1:0]     pp_lo_r;
  logic [tbm_pkg::PP_LO_W-1:0]     pp_lo_nxt;
  logic [tbm_pkg::PP_HI_W-1:0]     pp_hi_r;
  logic [tbm_pkg::PP_HI_W-1:0]     pp_hi_nxt;
  tbm_pkg::tbm_pkt_t               a_pkt_r;
  logic [tbm_pkg::PROD_W-1:0]      prod;
  logic [tbm_pkg::PROD_W-1:0]      shifted;
  logic                            over;
  logic [tbm_pkg::BITS_W-1:0]      earned_r;
  logic [tbm_pkg::BITS_W-1:0]      earned_nxt;
  tbm_pkg::tbm_pkt_t               b_pkt_r;

  assign b_adv    = !b_valid_r || dn_ready;
  assign a_adv    = !a_valid_r || b_adv;
  assign up_ready = a_adv;

  // stage a: two half-width partial products
  assign e_lo = up_elapsed[tbm_pkg::HALF_W-1:0];
  assign e_hi = up_elapsed[tbm_pkg::TIME_WIDTH-1:tbm_pkg::HALF_W];

  assign pp_lo_nxt = {{tbm_pkg::BITS_W{1'b0}}, e_lo} * {{tbm_pkg::HALF_W{1'b0}}, cfg.rate};
  assign pp_hi_nxt = {{tbm_pkg::BITS_W{1'b0}}, e_hi} * {{tbm_pkg::HI_W{1'b0}}, cfg.rate};

  // stage b: full product, drop fraction, saturate to 32 bits
  assign prod = {pp_hi_r, {tbm_pkg::HALF_W{1'b0}}} + {{tbm_pkg::HI_W{1'b0}}, pp_lo_r};
  assign shifted = prod >> tbm_pkg::RATE_FRAC_BITS;
  assign over = |shifted[tbm_pkg::PROD_W-1:tbm_pkg::BITS_W];
  assign earned_nxt = over ? {tbm_pkg::BITS_W{1'b1}} : shifted[tbm_pkg::BITS_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid_r <= up_valid;
      end
      if (b_adv) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (up_valid && a_adv) begin
      pp_lo_r <= pp_lo_nxt;
      pp_hi_r <= pp_hi_nxt;
      a_pkt_r <= up_pkt;
    end
    if (a_valid_r && b_adv) begin
      earned_r <= earned_nxt;
      b_pkt_r  <= a_pkt_r;
    end
  end

  assign dn_valid  = b_valid_r;
  assign dn_earned = earned_r;
  assign dn_pkt    = b_pkt_r;

endmodule

// ===== src/tbm_bucket.sv =====
// tbm_bucket: bucket state update, verdict and output register
// depends on tbm_pkg; one update per word, computed combinationally from the bucket register

module tbm_bucket (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tbm_pkg::tbm_cfg_t          cfg,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [tbm_pkg::BITS_W-1:0] up_earned,
  input  tbm_pkg::tbm_pkt_t          up_pkt,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_color,
  output logic [tbm_pkg::BITS_W-1:0] out_level
);

  logic                       valid_r;
  logic                       adv;
  logic                       take;
  logic [tbm_pkg::BITS_W-1:0] bucket_r;
  logic [tbm_pkg::BITS_W-1:0] bucket_nxt;
  logic [tbm_pkg::BITS_W:0]   sum;
  logic [tbm_pkg::BITS_W-1:0] clamped;
  logic [tbm_pkg::BITS_W-1:0] len_ext;
  logic                       color_ok;
  logic                       green;
  logic                       color_r;
  logic [tbm_pkg::BITS_W-1:0] level_r;

  assign adv      = !valid_r || out_ready;
  assign take     = up_valid && adv;
  assign up_ready = adv;

  // refill and clamp to the committed burst
  assign sum     = {1'b0, bucket_r} + {1'b0, up_earned};
  assign clamped = (sum > {1'b0, cfg.burst}) ? cfg.burst : sum[tbm_pkg::BITS_W-1:0];

  // conform check and deduction
  assign len_ext    = {{(tbm_pkg::BITS_W - tbm_pkg::LEN_W){1'b0}}, up_pkt.len};
  assign color_ok   = !cfg.aware || (up_pkt.color == tbm_pkg::IN_GREEN);
  assign green      = color_ok && (clamped >= len_ext);
  assign bucket_nxt = green ? (clamped - len_ext) : clamped;

  // control and bucket state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      bucket_r <= tbm_pkg::BURST_RESET;
    end else begin
      if (adv) begin
        valid_r <= up_valid;
      end
      if (take) begin
        bucket_r <= bucket_nxt;
      end
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (take) begin
      color_r <= green ? tbm_pkg::VERDICT_GREEN : tbm_pkg::VERDICT_RED;
      level_r <= bucket_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_color = color_r;
  assign out_level = level_r;

endmodule

// ===== src/token_bucket_meter_core.sv =====
// token_bucket_meter_core: top level of the single-rate two-color meter
// depends on tbm_pkg, tbm_delta, tbm_mult, tbm_bucket
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   arrival_time, packet_bits, in_color
//   out      output     out_valid / out_ready out_color, bucket_level
//   cfg      input      cfg_wr_en             cfg_index, cfg_wdata
//
// One word per cycle while the output is not stalled; an accepted word passes
// through four register stages: input, partial products, token sum, output.
// The rate is set by the bucket update, computed combinationally from the bucket register.
// Reset is synchronous: stages empty, bucket full, last arrival zero.
// A stalled output only fills the stages behind it; input stays ready while
// any stage holds a bubble.

module token_bucket_meter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tbm_pkg::TIME_WIDTH-1:0]      in_arrival_time,
  input  logic [tbm_pkg::LEN_W-1:0]           in_packet_bits,
  input  logic [tbm_pkg::COLOR_W-1:0]         in_color,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_color,
  output logic [tbm_pkg::BITS_W-1:0]          out_bucket_level,
  input  logic                                cfg_wr_en,
  input  logic [tbm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tbm_pkg::BITS_W-1:0]          cfg_wdata
);

  tbm_pkg::tbm_cfg_t              cfg_r;
  tbm_pkg::tbm_pkt_t              in_pkt;
  logic                           d_valid;
  logic                           d_ready;
  logic [tbm_pkg::TIME_WIDTH-1:0] d_elapsed;
  tbm_pkg::tbm_pkt_t              d_pkt;
  logic                           m_valid;
  logic                           m_ready;
  logic [tbm_pkg::BITS_W-1:0]     m_earned;
  tbm_pkg::tbm_pkt_t              m_pkt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.burst <= tbm_pkg::BURST_RESET;
      cfg_r.rate  <= tbm_pkg::RATE_RESET;
      cfg_r.aware <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tbm_pkg::CFG_BURST: cfg_r.burst <= cfg_wdata;
        tbm_pkg::CFG_RATE:  cfg_r.rate  <= cfg_wdata;
        tbm_pkg::CFG_AWARE: cfg_r.aware <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_pkt.len   = in_packet_bits;
  assign in_pkt.color = in_color;

  // elapsed ticks
  tbm_delta u_delta (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_valid),
    .up_ready   (in_ready),
    .up_time    (in_arrival_time),
    .up_pkt     (in_pkt),
    .dn_valid   (d_valid),
    .dn_ready   (d_ready),
    .dn_elapsed (d_elapsed),
    .dn_pkt     (d_pkt)
  );

  // earned tokens
  tbm_mult u_mult (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .up_valid   (d_valid),
    .up_ready   (d_ready),
    .up_elapsed (d_elapsed),
    .up_pkt     (d_pkt),
    .dn_valid   (m_valid),
    .dn_ready   (m_ready),
    .dn_earned  (m_earned),
    .dn_pkt     (m_pkt)
  );

  // bucket and verdict
  tbm_bucket u_bucket (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .up_valid  (m_valid),
    .up_ready  (m_ready),
    .up_earned (m_earned),
    .up_pkt    (m_pkt),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_color (out_color),
    .out_level (out_bucket_level)
  );

endmodule

// ===== src/tbm_checker.sv =====
// tbm_checker: port-level assertions for token_bucket_meter_core
// depends on tbm_pkg; attached to the top level by the bind below

module tbm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_color,
  input logic [tbm_pkg::BITS_W-1:0]      out_bucket_level
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_color) && $stable(out_bucket_level))
    else $error("result word changed while stalled");

  // a result word leaves only when taken
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result word dropped without acceptance");

  // the pipeline is empty coming out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // input backs up only behind a stalled, full output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input not ready without output backpressure");

endmodule

bind token_bucket_meter_core tbm_checker u_tbm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_color        (out_color),
  .out_bucket_level (out_bucket_level)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for token_bucket_meter_core, a two-color policer
// depends on tbm_pkg and the core; a local bucket model predicts every verdict

module tb_top;

  // color codes not named by the package
  localparam logic [tbm_pkg::COLOR_W-1:0] IN_YELLOW  = 2'd1;
  localparam logic [tbm_pkg::COLOR_W-1:0] IN_RED     = 2'd2;
  localparam logic [tbm_pkg::COLOR_W-1:0] IN_UNKNOWN = 2'd3;
  // index past the last register, writes there must be dropped
  localparam logic [tbm_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic [tbm_pkg::LEN_W-1:0]      LEN_MAX  = '1;
  localparam logic [tbm_pkg::TIME_WIDTH-1:0] TIME_MAX = '1;
  localparam int N_PHASES     = 12;
  localparam int PHASE_WORDS  = 140;
  localparam int STALL_AFTER  = 1000;
  localparam int STALL_CYCLES = 150;
  localparam int MAX_REPORTS  = 100;

  typedef struct packed {
    logic [tbm_pkg::TIME_WIDTH-1:0] stamp;
    logic [tbm_pkg::LEN_W-1:0]      len;
    logic [tbm_pkg::COLOR_W-1:0]    color;
  } arrival_t;

  typedef struct packed {
    logic                       color;
    logic [tbm_pkg::BITS_W-1:0] level;
  } verdict_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [tbm_pkg::TIME_WIDTH-1:0]  in_arrival_time = '0;
  logic [tbm_pkg::LEN_W-1:0]       in_packet_bits = '0;
  logic [tbm_pkg::COLOR_W-1:0]     in_color = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            out_color;
  logic [tbm_pkg::BITS_W-1:0]      out_bucket_level;
  logic                            cfg_wr_en = 1'b0;
  logic [tbm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [tbm_pkg::BITS_W-1:0]      cfg_wdata = '0;

  // bucket model: registers and state as they stand after reset
  logic [tbm_pkg::BITS_W-1:0]     m_burst  = tbm_pkg::BURST_RESET;
  logic [tbm_pkg::BITS_W-1:0]     m_rate   = tbm_pkg::RATE_RESET;
  logic                           m_aware  = 1'b0;
  logic [tbm_pkg::BITS_W-1:0]     m_bucket = tbm_pkg::BURST_RESET;
  logic [tbm_pkg::TIME_WIDTH-1:0] m_last   = '0;

  arrival_t arrival_q[$];
  verdict_t verdict_q[$];

  logic idle_on = 1'b1;
  int   n_errors = 0;
  int   n_items = 0;
  int   n_results = 0;
  int   n_green = 0;
  int   n_red = 0;
  int   n_writes = 0;
  int   n_settings = 1;
  int   cyc_count = 0;
  int   stall_left = 0;
  logic stall_done = 1'b0;

  token_bucket_meter_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_arrival_time  (in_arrival_time),
    .in_packet_bits   (in_packet_bits),
    .in_color         (in_color),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_color        (out_color),
    .out_bucket_level (out_bucket_level),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // refill by elapsed ticks, clamp to burst, then judge and deduct
  function automatic verdict_t police_packet(input logic [tbm_pkg::TIME_WIDTH-1:0] stamp,
                                             input logic [tbm_pkg::LEN_W-1:0] len,
                                             input logic [tbm_pkg::COLOR_W-1:0] color);
    logic [tbm_pkg::TIME_WIDTH-1:0] elapsed;
    logic [tbm_pkg::PROD_W-1:0]     product;
    logic [tbm_pkg::PROD_W-1:0]     whole;
    logic [tbm_pkg::BITS_W-1:0]     earned;
    logic [tbm_pkg::BITS_W:0]       level;
    verdict_t                       v;
    elapsed = stamp - m_last;
    product = (tbm_pkg::PROD_W)'(elapsed) * (tbm_pkg::PROD_W)'(m_rate);
    whole   = product >> tbm_pkg::RATE_FRAC_BITS;
    earned  = (whole > (tbm_pkg::PROD_W)'({tbm_pkg::BITS_W{1'b1}})) ? '1 :
              whole[tbm_pkg::BITS_W-1:0];
    level   = {1'b0, m_bucket} + {1'b0, earned};
    if (level > {1'b0, m_burst}) begin
      level = {1'b0, m_burst};
    end
    m_last = stamp;
    if ((!m_aware || color == tbm_pkg::IN_GREEN) &&
        level[tbm_pkg::BITS_W-1:0] >= (tbm_pkg::BITS_W)'(len)) begin
      level   = level - (tbm_pkg::BITS_W + 1)'(len);
      v.color = tbm_pkg::VERDICT_GREEN;
    end else begin
      v.color = tbm_pkg::VERDICT_RED;
    end
    m_bucket = level[tbm_pkg::BITS_W-1:0];
    v.level  = m_bucket;
    return v;
  endfunction

  // register write, mirrored into the model; only called while idle
  task automatic write_reg(input logic [tbm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [tbm_pkg::BITS_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      tbm_pkg::CFG_BURST: m_burst = val;
      tbm_pkg::CFG_RATE:  m_rate  = val;
      tbm_pkg::CFG_AWARE: m_aware = val[0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // block until nothing is pending, in flight or owed
  task automatic wait_quiet();
    while (arrival_q.size() != 0 || in_valid || verdict_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic queue_word(input logic [tbm_pkg::TIME_WIDTH-1:0] stamp,
                            input logic [tbm_pkg::LEN_W-1:0] len,
                            input logic [tbm_pkg::COLOR_W-1:0] color);
    arrival_t a;
    a.stamp = stamp;
    a.len   = len;
    a.color = color;
    arrival_q.push_back(a);
  endtask

  // sender: predicts at acceptance, then offers the next word or idles
  always @(posedge clk) begin : sender
    arrival_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        verdict_q.push_back(police_packet(in_arrival_time, in_packet_bits, in_color));
        n_items++;
      end
      if (!in_valid || in_ready) begin
        if (arrival_q.size() != 0 && !(idle_on && $urandom_range(0, 99) < 25)) begin
          nxt = arrival_q.pop_front();
          in_arrival_time <= nxt.stamp;
          in_packet_bits  <= nxt.len;
          in_color        <= nxt.color;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready: random stalls plus one long hold-off under load
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      cyc_count = cyc_count + 1;
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ready <= 1'b0;
      end else if (!stall_done && cyc_count > STALL_AFTER && in_valid &&
                   arrival_q.size() > 40) begin
        stall_done = 1'b1;
        stall_left = STALL_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_on && $urandom_range(0, 99) < 25);
      end
    end
  end

  // monitor: every accepted result against the oldest prediction
  always @(posedge clk) begin : monitor
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word color=%0d level=%0d",
                                  out_color, out_bucket_level));
      end else begin
        want = verdict_q.pop_front();
        if (out_color !== want.color) begin
          report_mismatch($sformatf("word %0d color got %0d want %0d",
                                    n_results, out_color, want.color));
        end
        if (out_bucket_level !== want.level) begin
          report_mismatch($sformatf("word %0d level got %0d want %0d",
                                    n_results, out_bucket_level, want.level));
        end
        if (want.color == tbm_pkg::VERDICT_GREEN) begin
          n_green++;
        end else begin
          n_red++;
        end
      end
      n_results++;
    end
  end

  // stimulus: directed corners, then random phases under varied settings
  initial begin
    logic [tbm_pkg::BITS_W-1:0]     burst_v;
    logic [tbm_pkg::BITS_W-1:0]     rate_v;
    logic [tbm_pkg::TIME_WIDTH-1:0] gen_time;
    logic [63:0]                    r64;
    arrival_t                       a;
    int                             span;
    int                             len_cap;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: full bucket, zero and oversize lengths, wrapped time
    queue_word(48'd0, '0, tbm_pkg::IN_GREEN);
    queue_word(48'd0, LEN_MAX, tbm_pkg::IN_GREEN);
    queue_word(48'd100, 17'd96000, IN_UNKNOWN);
    queue_word(48'd100, 17'd1, IN_RED);
    queue_word(48'd50, '0, tbm_pkg::IN_GREEN);
    queue_word(TIME_MAX, 17'd5000, IN_YELLOW);
    queue_word(TIME_MAX, '0, tbm_pkg::IN_GREEN);
    wait_quiet();

    // color-aware: only green arrivals may pass; dropped spare index write
    write_reg(CFG_SPARE, '1);
    write_reg(tbm_pkg::CFG_AWARE, 32'd1);
    n_settings++;
    @(negedge clk);
    queue_word(48'd10, 17'd100, tbm_pkg::IN_GREEN);
    queue_word(48'd10, 17'd100, IN_YELLOW);
    queue_word(48'd10, 17'd100, IN_RED);
    queue_word(48'd10, 17'd100, IN_UNKNOWN);
    queue_word(48'd10, '0, tbm_pkg::IN_GREEN);
    wait_quiet();

    // burst lowered below the level: clamp happens with no time elapsed
    write_reg(tbm_pkg::CFG_BURST, 32'd1000);
    n_settings++;
    @(negedge clk);
    queue_word(48'd10, '0, tbm_pkg::IN_GREEN);
    queue_word(48'd10, 17'd1001, tbm_pkg::IN_GREEN);
    queue_word(48'd10, 17'd1000, tbm_pkg::IN_GREEN);
    wait_quiet();

    // largest burst and rate: fractional refill and saturated product
    write_reg(tbm_pkg::CFG_BURST, '1);
    write_reg(tbm_pkg::CFG_RATE, '1);
    n_settings++;
    @(negedge clk);
    queue_word(48'd11, '0, tbm_pkg::IN_GREEN);
    queue_word(48'h8000_0000_0000, LEN_MAX, tbm_pkg::IN_GREEN);
    queue_word(48'h8000_0000_0000, LEN_MAX, tbm_pkg::IN_GREEN);
    wait_quiet();

    // zero rate, then zero burst
    write_reg(tbm_pkg::CFG_RATE, '0);
    n_settings++;
    @(negedge clk);
    queue_word(48'h4000_0000_0000, 17'd17, tbm_pkg::IN_GREEN);
    wait_quiet();
    write_reg(tbm_pkg::CFG_BURST, '0);
    n_settings++;
    @(negedge clk);
    queue_word(48'h4000_0000_0001, '0, tbm_pkg::IN_GREEN);
    queue_word(48'h4000_0000_0002, 17'd1, tbm_pkg::IN_GREEN);
    wait_quiet();

    // random phases: mostly steady arrivals, some arbitrary timestamps
    gen_time = 48'h4000_0000_0002;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_quiet();
      case ($urandom_range(0, 5))
        0:       burst_v = '0;
        1:       burst_v = '1;
        2:       burst_v = $urandom_range(1, 4000);
        5:       burst_v = $urandom;
        default: burst_v = $urandom_range(20000, 300000);
      endcase
      case ($urandom_range(0, 5))
        0:       rate_v = '0;
        1:       rate_v = '1;
        2:       rate_v = $urandom_range(1, 65535);
        5:       rate_v = $urandom;
        default: rate_v = $urandom_range(65536, 65536 * 16);
      endcase
      write_reg(tbm_pkg::CFG_BURST, burst_v);
      write_reg(tbm_pkg::CFG_RATE, rate_v);
      write_reg(tbm_pkg::CFG_AWARE, $urandom);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_SPARE, $urandom);
      end
      n_settings++;
      case ($urandom_range(0, 3))
        0:       span = 4;
        1:       span = 200;
        2:       span = 5000;
        default: span = 100000;
      endcase
      case ($urandom_range(0, 2))
        0:       len_cap = 131071;
        1:       len_cap = 12000;
        default: len_cap = 1500;
      endcase
      // one phase runs with no gaps on either side
      idle_on = (ph != 2);
      @(negedge clk);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if ($urandom_range(0, 99) < 85) begin
          gen_time = gen_time + $urandom_range(0, span);
          a.stamp  = gen_time;
          a.len    = (tbm_pkg::LEN_W)'($urandom_range(0, len_cap));
          a.color  = ($urandom_range(0, 99) < 70) ? tbm_pkg::IN_GREEN :
                     (tbm_pkg::COLOR_W)'($urandom_range(1, 3));
        end else begin
          r64      = {$urandom, $urandom};
          a.stamp  = r64[tbm_pkg::TIME_WIDTH-1:0];
          gen_time = a.stamp;
          a.len    = (tbm_pkg::LEN_W)'($urandom);
          a.color  = (tbm_pkg::COLOR_W)'($urandom);
        end
        arrival_q.push_back(a);
      end
    end

    // drain, let the pipeline settle, then judge
    wait_quiet();
    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
    end
    $display("metered %0d packets under %0d register settings: %0d green, %0d red",
             n_items, n_settings, n_green, n_red);
    $display("%0d register writes, output held off %0d cycles once, %0d mismatches",
             n_writes, STALL_CYCLES, n_errors);
    if (n_errors == 0) begin
      $display("token_bucket_meter_core verification clean");
    end else begin
      $display("token_bucket_meter_core verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("token_bucket_meter_core verification failed");
    $finish;
  end

endmodule
